// ----- src/srt_pkg.sv -----
// Shared types and codes for the sorted record table.
// Used by the channel interfaces, controller, datapath and top level.
package srt_pkg;

   localparam int YEAR_W   = 16;
   localparam int FLOW_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 2'd0,
      MODE_REMOVE  = 2'd1,
      MODE_RESET   = 2'd2,
      MODE_FORWARD = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [FLOW_W-1:0] flow;
   } rec_type;

   // One datapath operation per cycle, chosen by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_FULL,
      OP_INS_INIT,
      OP_INS_HEAD,
      OP_INS_READ,
      OP_INS_PLACE,
      OP_INS_SHIFT,
      OP_REM_INIT,
      OP_REM_READ,
      OP_REM_STEP,
      OP_REM_END,
      OP_CUR_RESET,
      OP_CUR_FWD,
      OP_CUR_READ,
      OP_RSP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     ptr_zero;
      logic     ptr_end;
      logic     ins_here;
      logic     rsp_busy;
   } dp_stat_type;

endpackage

// ----- src/srt_req_if.sv -----
// Request channel of the sorted record table: valid/ready plus one operation word.
// Depends on srt_pkg for the field widths.
interface srt_req_if;
   import srt_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [YEAR_W-1:0] year;
   logic [FLOW_W-1:0] flow;

   modport source (output valid, output mode, output year, output flow, input ready);
   modport sink   (input valid, input mode, input year, input flow, output ready);
endinterface

// ----- src/srt_rsp_if.sv -----
// Response channel of the sorted record table: valid/ready plus one result word.
// Depends on srt_pkg for the field widths; CNT_W follows the table depth.
interface srt_rsp_if #(
   parameter int CNT_W = 7
);
   import srt_pkg::*;

   logic                valid;
   logic                ready;
   logic [CNT_W-1:0]    record_count;
   logic                cursor_valid;
   logic [YEAR_W-1:0]   cursor_year;
   logic [FLOW_W-1:0]   cursor_flow;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output record_count, output cursor_valid,
                   output cursor_year, output cursor_flow, output status, input ready);
   modport sink   (input valid, input record_count, input cursor_valid,
                   input cursor_year, input cursor_flow, input status, output ready);
endinterface

// ----- src/srt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/srt_ctrl.sv -----
// Controller of the sorted record table: sequences each operation as datapath commands.
// Depends on srt_pkg for the command and status structs.
module srt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  srt_pkg::dp_stat_type stat,
   output srt_pkg::dp_cmd_type  cmd
);
   import srt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_REM_RD,
      ST_REM_CMP,
      ST_CUR_RD,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            unique case (stat.mode)
               MODE_INSERT: begin
                  if (stat.full) begin
                     cmd.op   = OP_FULL;
                     state_in = ST_FINISH;
                  end else begin
                     cmd.op   = OP_INS_INIT;
                     state_in = ST_INS_RD;
                  end
               end
               MODE_REMOVE: begin
                  cmd.op   = OP_REM_INIT;
                  state_in = ST_REM_RD;
               end
               MODE_RESET: begin
                  cmd.op   = OP_CUR_RESET;
                  state_in = ST_CUR_RD;
               end
               MODE_FORWARD: begin
                  cmd.op   = OP_CUR_FWD;
                  state_in = ST_CUR_RD;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_INS_RD: begin
            if (stat.ptr_zero) begin
               cmd.op   = OP_INS_HEAD;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_INS_READ;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (stat.ins_here) begin
               cmd.op   = OP_INS_PLACE;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_INS_SHIFT;
               state_in = ST_INS_RD;
            end
         end
         ST_REM_RD: begin
            if (stat.ptr_end) begin
               cmd.op   = OP_REM_END;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_REM_READ;
               state_in = ST_REM_CMP;
            end
         end
         ST_REM_CMP: begin
            cmd.op   = OP_REM_STEP;
            state_in = ST_REM_RD;
         end
         ST_CUR_RD: begin
            cmd.op   = OP_CUR_READ;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_RSP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ready_in = (state_in == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;
endmodule

// ----- src/srt_dp.sv -----
// Datapath of the sorted record table: record store, count, cursor, scan pointer
// and output register. Depends on srt_pkg and srt_ram.
module srt_dp #(
   parameter int TABLE_DEPTH = 64,
   parameter int CNT_W       = $clog2(TABLE_DEPTH + 1),
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srt_pkg::dp_cmd_type           cmd,
   output srt_pkg::dp_stat_type          stat,
   input  logic [srt_pkg::MODE_W-1:0]    req_mode,
   input  logic [srt_pkg::YEAR_W-1:0]    req_year,
   input  logic [srt_pkg::FLOW_W-1:0]    req_flow,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CNT_W-1:0]              rsp_record_count,
   output logic                          rsp_cursor_valid,
   output logic [srt_pkg::YEAR_W-1:0]    rsp_cursor_year,
   output logic [srt_pkg::FLOW_W-1:0]    rsp_cursor_flow,
   output logic [srt_pkg::STATUS_W-1:0]  rsp_status
);
   import srt_pkg::*;

   localparam int REC_W = $bits(rec_type);

   mode_type          mode_ff;
   logic [YEAR_W-1:0] year_ff;
   logic [FLOW_W-1:0] flow_ff;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  cur_idx_ff, cur_idx_in;
   logic              cur_on_ff, cur_on_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              found_ff, found_in;

   logic                rsp_valid_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                rsp_cv_ff;
   logic [YEAR_W-1:0]   rsp_year_ff;
   logic [FLOW_W-1:0]   rsp_flow_ff;
   status_type          rsp_status_ff;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   rec_type          wr_rec, rd_rec;
   logic [REC_W-1:0] rd_data;
   logic [CNT_W-1:0] ptr_dec;
   logic [CNT_W-1:0] cur_next;

   srt_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_rec   = rec_type'(rd_data);
   assign ptr_dec  = ptr_ff - CNT_W'(1);
   assign cur_next = CNT_W'(cur_idx_ff) + CNT_W'(1);

   assign stat.mode     = mode_ff;
   assign stat.full     = (count_ff == CNT_W'(TABLE_DEPTH));
   assign stat.ptr_zero = (ptr_ff == '0);
   assign stat.ptr_end  = (ptr_ff == count_ff);
   assign stat.ins_here = (flow_ff > rd_rec.flow);
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      status_in  = status_ff;
      count_in   = count_ff;
      cur_idx_in = cur_idx_ff;
      cur_on_in  = cur_on_ff;
      ptr_in     = ptr_ff;
      found_in   = found_ff;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff[IDX_W-1:0];
      wr_rec     = rd_rec;
      rd_en      = 1'b0;
      rd_addr    = ptr_ff[IDX_W-1:0];
      unique case (cmd.op)
         OP_LOAD: begin
            status_in = STATUS_OK;
         end
         OP_FULL: begin
            status_in  = STATUS_FULL;
            cur_on_in  = 1'b0;
            cur_idx_in = '0;
         end
         OP_INS_INIT: begin
            // Walk down from the end: each record above the new one moves up a slot.
            ptr_in     = count_ff;
            cur_on_in  = 1'b0;
            cur_idx_in = '0;
         end
         OP_INS_HEAD: begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            wr_rec.year = year_ff;
            wr_rec.flow = flow_ff;
            count_in    = count_ff + CNT_W'(1);
         end
         OP_INS_READ: begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec[IDX_W-1:0];
         end
         OP_INS_PLACE: begin
            wr_en       = 1'b1;
            wr_rec.year = year_ff;
            wr_rec.flow = flow_ff;
            count_in    = count_ff + CNT_W'(1);
         end
         OP_INS_SHIFT: begin
            wr_en  = 1'b1;
            ptr_in = ptr_dec;
         end
         OP_REM_INIT: begin
            ptr_in     = '0;
            found_in   = 1'b0;
            cur_on_in  = 1'b0;
            cur_idx_in = '0;
         end
         OP_REM_READ: begin
            rd_en = 1'b1;
         end
         OP_REM_STEP: begin
            // After the first match every later record moves down one slot.
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_dec[IDX_W-1:0];
            end else if (rd_rec.year == year_ff) begin
               found_in = 1'b1;
            end
            ptr_in = ptr_ff + CNT_W'(1);
         end
         OP_REM_END: begin
            if (found_ff) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         OP_CUR_RESET: begin
            cur_idx_in = '0;
            cur_on_in  = (count_ff != '0);
         end
         OP_CUR_FWD: begin
            if (cur_on_ff && (cur_next < count_ff)) begin
               cur_idx_in = cur_idx_ff + IDX_W'(1);
            end else begin
               cur_on_in  = 1'b0;
               cur_idx_in = '0;
            end
         end
         OP_CUR_READ: begin
            rd_en   = 1'b1;
            rd_addr = cur_idx_ff;
         end
         OP_RSP_LOAD, OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cur_idx_ff   <= '0;
         cur_on_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cur_idx_ff <= cur_idx_in;
         cur_on_ff  <= cur_on_in;
         if (cmd.op == OP_RSP_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      ptr_ff    <= ptr_in;
      found_ff  <= found_in;
      if (cmd.op == OP_LOAD) begin
         mode_ff <= mode_type'(req_mode);
         year_ff <= req_year;
         flow_ff <= req_flow;
      end
      if (cmd.op == OP_RSP_LOAD) begin
         rsp_count_ff  <= count_ff;
         rsp_cv_ff     <= cur_on_ff;
         rsp_year_ff   <= cur_on_ff ? rd_rec.year : '0;
         rsp_flow_ff   <= cur_on_ff ? rd_rec.flow : '0;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_count = rsp_count_ff;
   assign rsp_cursor_valid = rsp_cv_ff;
   assign rsp_cursor_year  = rsp_year_ff;
   assign rsp_cursor_flow  = rsp_flow_ff;
   assign rsp_status       = rsp_status_ff;
endmodule

// ----- src/sorted_record_table_unit.sv -----
// Sorted record table: top level joining the controller and the datapath.
// Depends on srt_pkg, srt_req_if, srt_rsp_if, srt_ctrl and srt_dp.
//
// Usage. Each word on the request channel is one operation: insert a
// (year, flow) record in ascending flow order, remove the first record with a
// given year, put the cursor on the first record, or move the cursor forward.
// Every request yields exactly one response word carrying the record count,
// the cursor's record (zero when the cursor is invalid) and a status code.
//
// Sequencing. One operation at a time; the insert and remove walks step
// through the single RAM one record at a time. A cursor operation reads
// its record and an insert into a full table goes straight to the
// response; a remove walks every record, and an insert walks down from the
// end until a record stays below the new one or the head is reached. The
// next request is taken once the controller is back in idle.
//
// Reset clears the count and the cursor at once; there is no clearing pass.
// If the receiver stalls, the response is held in the output register and
// the next request is still accepted and worked on; it waits at its end
// until the previous response word has been taken.
module sorted_record_table_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input logic      clock,
   input logic      reset,
   srt_req_if.sink  req_bus,
   srt_rsp_if.source rsp_bus
);
   import srt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   // The controller owns the request handshake and sequences the datapath.
   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   // The datapath holds the store, the cursor and the response register.
   srt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_bus.mode),
      .req_year         (req_bus.year),
      .req_flow         (req_bus.flow),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_record_count (rsp_bus.record_count),
      .rsp_cursor_valid (rsp_bus.cursor_valid),
      .rsp_cursor_year  (rsp_bus.cursor_year),
      .rsp_cursor_flow  (rsp_bus.cursor_flow),
      .rsp_status       (rsp_bus.status)
   );
endmodule
